/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`define ASSERT_SAME(lbl, ante, cons, msg)
`endif
`endif

/* hdl/rsjls_pkg.sv */
// ----------------------------------------------------------------------------
// rsjls_pkg
// types and constants of the rtp jitter and loss statistics block
// ----------------------------------------------------------------------------
package rsjls_pkg;

  localparam logic CFG_CODEC_KNOWN = 1'b0;
  localparam logic CFG_CLOCK_RATE  = 1'b1;

  localparam logic [17:0] CLOCK_RATE_RESET = 18'd8000;
  localparam logic [31:0] TS_SCALE         = 32'd256000000;
  localparam logic signed [16:0] NEW_CYCLE_DROP = 17'sd240;
  localparam logic [16:0] SEQ_SPAN         = 17'd65536;
  localparam int unsigned JIT_SHIFT        = 4;

  localparam int unsigned DVD_W   = 72;
  localparam int unsigned DSR_W   = 33;
  localparam int unsigned Q_W     = 64;
  localparam int unsigned DCNT_W  = 7;
  localparam logic [DCNT_W-1:0] TS_DIV_STEPS  = 7'd61;
  localparam logic [DCNT_W-1:0] AVG_DIV_STEPS = 7'd40;

  typedef enum logic [2:0] {
    ST_UNANALYZED = 3'd0,
    ST_FIRST      = 3'd1,
    ST_IN_ORDER   = 3'd2,
    ST_WRAP       = 3'd3,
    ST_NEW_CYCLE  = 3'd4,
    ST_GAP        = 3'd5,
    ST_LATE       = 3'd6
  } seq_status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_MUL_TS, S_DIVTS_GO, S_DIVTS_WAIT, S_JIT1, S_JIT2,
    S_MUL_LO, S_MUL_HI, S_ACC, S_DIVAVG_GO, S_DIVAVG_WAIT, S_FIN
  } fsm_t;

  typedef struct packed {
    logic              start;
    logic [DCNT_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* hdl/rsjls_if.sv */
// ----------------------------------------------------------------------------
// rsjls channel interfaces
// valid/ready channels for packet items and statistics results
// ----------------------------------------------------------------------------
interface rsjls_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] arrival_time_us;
  logic [31:0] rtp_timestamp;
  logic [15:0] rtp_sequence;
  modport source (output valid, arrival_time_us, rtp_timestamp, rtp_sequence, input ready);
  modport sink (input valid, arrival_time_us, rtp_timestamp, rtp_sequence, output ready);
endinterface

interface rsjls_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         seq_status;
  logic [31:0]        packets_seen;
  logic [31:0]        out_of_sequence;
  logic [31:0]        expected_packets;
  logic signed [31:0] lost_packets;
  logic [47:0]        max_gap_us;
  logic [39:0]        jitter_now;
  logic [39:0]        jitter_max;
  logic [39:0]        jitter_mean;
  modport source (output valid, seq_status, packets_seen, out_of_sequence, expected_packets,
                  lost_packets, max_gap_us, jitter_now, jitter_max, jitter_mean,
                  input ready);
  modport sink (input valid, seq_status, packets_seen, out_of_sequence, expected_packets,
                lost_packets, max_gap_us, jitter_now, jitter_max, jitter_mean,
                output ready);
endinterface

/* hdl/rsjls_div.sv */
// ----------------------------------------------------------------------------
// rsjls_div
// restoring divider, one quotient bit per cycle, shared by both divisions
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsjls_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rsjls_pkg::div_ctl_t            ctl,
  input  logic [rsjls_pkg::DSR_W-1:0]    rem0,
  input  logic [rsjls_pkg::DVD_W-1:0]    sh0,
  input  logic [rsjls_pkg::DSR_W-1:0]    divisor,
  output rsjls_pkg::div_sts_t            sts,
  output logic [rsjls_pkg::Q_W-1:0]      quot
);

  logic [rsjls_pkg::DCNT_W-1:0] cnt_r;
  logic                         done_r;
  logic [rsjls_pkg::DSR_W-1:0]  rem_r;
  logic [rsjls_pkg::DVD_W-1:0]  sh_r;
  logic [rsjls_pkg::DSR_W-1:0]  dsr_r;
  logic [rsjls_pkg::Q_W-1:0]    q_r;
  logic [rsjls_pkg::DSR_W:0]    trial;
  logic [rsjls_pkg::DSR_W:0]    diff;
  logic                         take;

  assign trial = {rem_r, sh_r[rsjls_pkg::DVD_W-1]};
  assign take  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (ctl.start) begin
      cnt_r  <= ctl.steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= rem0;
      sh_r  <= sh0;
      dsr_r <= divisor;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= take ? diff[rsjls_pkg::DSR_W-1:0] : trial[rsjls_pkg::DSR_W-1:0];
      sh_r  <= {sh_r[rsjls_pkg::DVD_W-2:0], 1'b0};
      q_r   <= {q_r[rsjls_pkg::Q_W-2:0], take};
    end
  end

  assign sts.busy = cnt_r != '0;
  assign sts.done = done_r;
  assign quot     = q_r;

  `ASSERT_NEXT(a_start_clears_done, ctl.start, !done_r && cnt_r != '0, "divider start did not clear done")
  `ASSERT_SAME(a_done_idle, done_r, cnt_r == '0, "divider done while still stepping")
  `ASSERT_SAME(a_start_steps, ctl.start, ctl.steps != '0, "divider started with no steps")

endmodule

/* hdl/rtp_stream_jitter_loss_stats_top.sv */
// ----------------------------------------------------------------------------
// rtp_stream_jitter_loss_stats_top
// per packet sequence tracking, loss counts and rfc 3550 interarrival jitter
// ----------------------------------------------------------------------------
// sequencing: an analyzed packet goes from decode through timestamp scaling and division,
//   the jitter update, the mean multiply, accumulate and division to the result register;
//   unknown codec, first or late packets go from decode straight to the result register
// throughput: one packet at a time; input is taken again only after the result is loaded,
//   which waits on a stalled receiver; the divider gives one quotient bit per cycle
// reset: synchronous active-low rst_n clears all statistics, codec_known 0, clock 8000
`include "assert_macros.svh"

module rtp_stream_jitter_loss_stats_top (
  input  logic               clk,
  input  logic               rst_n,
  rsjls_in_if.sink           in_ch,
  rsjls_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [17:0]        cfg_wdata
);

  // state machine
  rsjls_pkg::fsm_t        state_r, state_nxt;

  // configuration
  logic                   codec_known_r;
  logic [17:0]            clock_rate_r;

  // captured packet
  logic [47:0]            arr_r;
  logic [31:0]            ts_r;
  logic [15:0]            seq_r;

  // running statistics
  logic [31:0]            count_r;
  logic [47:0]            last_arrival_r;
  logic [31:0]            last_stamp_r;
  logic [15:0]            last_seq_r;
  logic [15:0]            base_seq_r;
  logic [31:0]            cycled_r;
  logic [31:0]            oos_r;
  logic [47:0]            gap_max_r;
  logic [39:0]            jitter_r;
  logic [39:0]            peak_r;
  logic [39:0]            avg_r;
  logic [31:0]            expected_r;
  logic signed [31:0]     lost_r;
  rsjls_pkg::seq_status_t status_r;

  // work registers
  logic signed [48:0]     dr_r;
  logic [32:0]            mag_r;
  logic                   neg_r;
  logic [61:0]            ad_r;
  logic [64:0]            mul_p_r;
  logic [71:0]            acc_r;

  // result register
  logic                   out_valid_r;
  logic [2:0]             o_status_r;
  logic [31:0]            o_seen_r, o_oos_r, o_exp_r;
  logic signed [31:0]     o_lost_r;
  logic [47:0]            o_gap_r;
  logic [39:0]            o_jit_r, o_peak_r, o_avg_r;

  // shared multiplier and divider hookup
  logic [32:0]            mul_a;
  logic [31:0]            mul_b;
  logic [64:0]            mul_prod;
  rsjls_pkg::div_ctl_t    div_ctl;
  rsjls_pkg::div_sts_t    div_sts;
  logic [32:0]            div_rem0;
  logic [71:0]            div_sh0;
  logic [32:0]            div_dsr;
  logic [63:0]            div_quot;

  logic                   in_xfer;
  logic                   out_load;

  // sequence decision signals
  logic [31:0]            cnt_inc;
  logic [16:0]            seq_next;
  logic signed [16:0]     seq_drop;
  logic                   is_inorder, is_wrap, is_newcyc, is_gap;
  logic [32:0]            cyc_sum;
  logic [31:0]            cyc_nx, cyc_use;
  logic [15:0]            base_use;
  logic signed [34:0]     ex_val;
  logic [31:0]            ex_clamp;
  logic signed [32:0]     ts_diff;
  logic signed [48:0]     dr_now;
  logic [31:0]            oos_inc;

  // jitter path signals
  logic signed [62:0]     dr256, ds_s, d_val, d_abs;
  logic [61:0]            j_up_sum;
  logic [39:0]            nj;
  logic signed [33:0]     lost_diff;
  logic [17:0]            clk_eff;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = state_r == rsjls_pkg::S_IDLE;
  assign out_load = state_r == rsjls_pkg::S_FIN && (!out_valid_r || out_ch.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_known_r <= 1'b0;
      clock_rate_r  <= rsjls_pkg::CLOCK_RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rsjls_pkg::CFG_CODEC_KNOWN: codec_known_r <= cfg_wdata[0];
        rsjls_pkg::CFG_CLOCK_RATE:  clock_rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequence classification against the last accepted sequence number
  assign cnt_inc    = (count_r == '1) ? count_r : count_r + 32'd1;
  assign oos_inc    = (oos_r == '1) ? oos_r : oos_r + 32'd1;
  assign seq_next   = {1'b0, last_seq_r} + 17'd1;
  assign seq_drop   = $signed({1'b0, last_seq_r}) - $signed({1'b0, seq_r});
  assign is_inorder = seq_next == {1'b0, seq_r};
  assign is_wrap    = last_seq_r == 16'hFFFF && seq_r == 16'd0;
  assign is_newcyc  = seq_drop > rsjls_pkg::NEW_CYCLE_DROP;
  assign is_gap     = seq_next < {1'b0, seq_r};

  // cycle wrap adds what is left of the sequence span, saturating
  assign cyc_sum  = {1'b0, cycled_r} + {16'd0, rsjls_pkg::SEQ_SPAN - {1'b0, base_seq_r}};
  assign cyc_nx   = cyc_sum[32] ? '1 : cyc_sum[31:0];
  assign cyc_use  = (!is_inorder && (is_wrap || is_newcyc)) ? cyc_nx : cycled_r;
  assign base_use = (!is_inorder && (is_wrap || is_newcyc)) ? 16'd0 : base_seq_r;
  assign ex_val   = $signed({3'b0, cyc_use}) + $signed({19'b0, seq_r})
                  - $signed({19'b0, base_use}) + 35'sd1;
  assign ex_clamp = ex_val < 0 ? 32'd0 : (ex_val[34:32] != 3'b0 ? '1 : ex_val[31:0]);

  assign ts_diff  = $signed({1'b0, ts_r}) - $signed({1'b0, last_stamp_r});
  assign dr_now   = $signed({1'b0, arr_r}) - $signed({1'b0, last_arrival_r});

  // loss, clamped to the signed 32-bit range
  assign lost_diff = $signed({2'b0, expected_r}) - $signed({2'b0, count_r});

  // transit difference in q.8 microseconds
  assign dr256 = $signed({{6{dr_r[48]}}, dr_r, 8'b0});
  assign ds_s  = $signed({2'b0, div_quot[60:0]});
  assign d_val = neg_r ? dr256 + ds_s : dr256 - ds_s;
  assign d_abs = d_val[62] ? -d_val : d_val;

  // j += (|d| - j) / 16, toward zero, saturating at 40 bits
  assign j_up_sum = {22'b0, jitter_r} + ((ad_r - {22'b0, jitter_r}) >> rsjls_pkg::JIT_SHIFT);
  always_comb begin
    if (ad_r >= {22'b0, jitter_r}) begin
      nj = (j_up_sum[61:40] != '0) ? '1 : j_up_sum[39:0];
    end else begin
      nj = jitter_r - ((jitter_r - ad_r[39:0]) >> rsjls_pkg::JIT_SHIFT);
    end
  end

  assign clk_eff  = (clock_rate_r == '0) ? 18'd1 : clock_rate_r;
  assign mul_prod = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsjls_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = rsjls_pkg::S_DEC;
      end
      rsjls_pkg::S_DEC: begin
        priority if (!codec_known_r || cnt_inc == 32'd1) state_nxt = rsjls_pkg::S_FIN;
        else if (is_inorder || is_wrap || is_newcyc || is_gap) state_nxt = rsjls_pkg::S_MUL_TS;
        else state_nxt = rsjls_pkg::S_FIN;
      end
      rsjls_pkg::S_MUL_TS:     state_nxt = rsjls_pkg::S_DIVTS_GO;
      rsjls_pkg::S_DIVTS_GO:   state_nxt = rsjls_pkg::S_DIVTS_WAIT;
      rsjls_pkg::S_DIVTS_WAIT: begin
        if (div_sts.done) state_nxt = rsjls_pkg::S_JIT1;
      end
      rsjls_pkg::S_JIT1:       state_nxt = rsjls_pkg::S_JIT2;
      rsjls_pkg::S_JIT2:       state_nxt = rsjls_pkg::S_MUL_LO;
      rsjls_pkg::S_MUL_LO:     state_nxt = rsjls_pkg::S_MUL_HI;
      rsjls_pkg::S_MUL_HI:     state_nxt = rsjls_pkg::S_ACC;
      rsjls_pkg::S_ACC:        state_nxt = rsjls_pkg::S_DIVAVG_GO;
      rsjls_pkg::S_DIVAVG_GO:  state_nxt = rsjls_pkg::S_DIVAVG_WAIT;
      rsjls_pkg::S_DIVAVG_WAIT: begin
        if (div_sts.done) state_nxt = rsjls_pkg::S_FIN;
      end
      rsjls_pkg::S_FIN: begin
        if (out_load) state_nxt = rsjls_pkg::S_IDLE;
      end
      default: state_nxt = rsjls_pkg::S_IDLE;
    endcase
  end

  // shared unit control
  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_ctl.start = 1'b0;
    div_ctl.steps = rsjls_pkg::TS_DIV_STEPS;
    div_rem0      = '0;
    div_sh0       = {mul_p_r[60:0], 11'b0};
    div_dsr       = {15'b0, clk_eff};
    unique case (state_r)
      rsjls_pkg::S_MUL_TS: begin
        mul_a = mag_r;
        mul_b = rsjls_pkg::TS_SCALE;
      end
      rsjls_pkg::S_DIVTS_GO: begin
        div_ctl.start = 1'b1;
      end
      rsjls_pkg::S_MUL_LO: begin
        mul_a = {1'b0, avg_r[31:0]};
        mul_b = count_r;
      end
      rsjls_pkg::S_MUL_HI: begin
        mul_a = {25'b0, avg_r[39:32]};
        mul_b = count_r;
      end
      rsjls_pkg::S_DIVAVG_GO: begin
        // quotient stays below 2^40, so the top bits preload the remainder
        div_ctl.start = 1'b1;
        div_ctl.steps = rsjls_pkg::AVG_DIV_STEPS;
        div_rem0      = {1'b0, acc_r[71:40]};
        div_sh0       = {acc_r[39:0], 32'b0};
        div_dsr       = {1'b0, count_r} + 33'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rsjls_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  rsjls_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .rem0    (div_rem0),
    .sh0     (div_sh0),
    .divisor (div_dsr),
    .sts     (div_sts),
    .quot    (div_quot)
  );

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    mul_p_r <= mul_prod;
    if (in_xfer) begin
      arr_r <= in_ch.arrival_time_us;
      ts_r  <= in_ch.rtp_timestamp;
      seq_r <= in_ch.rtp_sequence;
    end
    if (state_r == rsjls_pkg::S_DEC) begin
      dr_r  <= dr_now;
      neg_r <= ts_diff[32];
      mag_r <= ts_diff[32] ? 33'(-ts_diff) : 33'(ts_diff);
    end
    if (state_r == rsjls_pkg::S_JIT1) ad_r <= d_abs[61:0];
    if (state_r == rsjls_pkg::S_MUL_HI) acc_r <= {8'b0, mul_p_r[63:0]} + {32'b0, jitter_r};
    if (state_r == rsjls_pkg::S_ACC) acc_r <= acc_r + {mul_p_r[39:0], 32'b0};
  end

  // statistics
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      last_arrival_r <= '0;
      last_stamp_r   <= '0;
      last_seq_r     <= '0;
      base_seq_r     <= '0;
      cycled_r       <= '0;
      oos_r          <= '0;
      gap_max_r      <= '0;
      jitter_r       <= '0;
      peak_r         <= '0;
      avg_r          <= '0;
      expected_r     <= '0;
      lost_r         <= '0;
      status_r       <= rsjls_pkg::ST_UNANALYZED;
    end else begin
      unique case (state_r)
        rsjls_pkg::S_DEC: begin
          count_r <= cnt_inc;
          priority if (!codec_known_r) begin
            status_r <= rsjls_pkg::ST_UNANALYZED;
          end else if (cnt_inc == 32'd1) begin
            // first analyzed packet only sets the references
            status_r       <= rsjls_pkg::ST_FIRST;
            last_arrival_r <= arr_r;
            last_stamp_r   <= ts_r;
            last_seq_r     <= seq_r;
            base_seq_r     <= seq_r;
          end else if (is_inorder || is_wrap || is_newcyc || is_gap) begin
            priority if (is_inorder) status_r <= rsjls_pkg::ST_IN_ORDER;
            else if (is_wrap) status_r <= rsjls_pkg::ST_WRAP;
            else if (is_newcyc) status_r <= rsjls_pkg::ST_NEW_CYCLE;
            else begin
              status_r <= rsjls_pkg::ST_GAP;
              oos_r    <= oos_inc;
            end
            last_seq_r     <= seq_r;
            cycled_r       <= cyc_use;
            base_seq_r     <= base_use;
            expected_r     <= ex_clamp;
            last_arrival_r <= arr_r;
            last_stamp_r   <= ts_r;
            // a negative gap never raises the maximum
            if (!dr_now[48] && dr_now[47:0] > gap_max_r) gap_max_r <= dr_now[47:0];
          end else begin
            // late or duplicate packet: counted, nothing else moves
            status_r <= rsjls_pkg::ST_LATE;
            oos_r    <= oos_inc;
          end
        end
        rsjls_pkg::S_MUL_TS: begin
          priority if (lost_diff > 34'sh0_7FFF_FFFF) lost_r <= 32'sh7FFF_FFFF;
          else if (lost_diff < -34'sh0_8000_0000) lost_r <= 32'sh8000_0000;
          else lost_r <= lost_diff[31:0];
        end
        rsjls_pkg::S_JIT2: begin
          jitter_r <= nj;
          if (nj > peak_r) peak_r <= nj;
        end
        rsjls_pkg::S_DIVAVG_WAIT: begin
          if (div_sts.done) avg_r <= div_quot[39:0];
        end
        default: ;
      endcase
    end
  end

  // result register, frees the sequencer while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_status_r <= status_r;
      o_seen_r   <= count_r;
      o_oos_r    <= oos_r;
      o_exp_r    <= expected_r;
      o_lost_r   <= lost_r;
      o_gap_r    <= gap_max_r;
      o_jit_r    <= jitter_r;
      o_peak_r   <= peak_r;
      o_avg_r    <= avg_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.seq_status       = o_status_r;
  assign out_ch.packets_seen     = o_seen_r;
  assign out_ch.out_of_sequence  = o_oos_r;
  assign out_ch.expected_packets = o_exp_r;
  assign out_ch.lost_packets     = o_lost_r;
  assign out_ch.max_gap_us       = o_gap_r;
  assign out_ch.jitter_now       = o_jit_r;
  assign out_ch.jitter_max       = o_peak_r;
  assign out_ch.jitter_mean      = o_avg_r;

  `ASSERT_ALWAYS(a_peak_ge_now, peak_r >= jitter_r, "jitter peak below current jitter")
  `ASSERT_SAME(a_valid_from_fin, $rose(out_valid_r), $past(state_r == rsjls_pkg::S_FIN), "result shown outside finish")
  `ASSERT_NEXT(a_accept_to_dec, in_xfer, state_r == rsjls_pkg::S_DEC, "accepted packet not decoded")

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// rtp stream jitter and loss statistics testbench
// drives packet items through valid/ready with bursty traffic and a stalling
// receiver, predicts every statistics result and checks each transfer field by
// field; configuration changes between phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] arr;
    logic [31:0] ts;
    logic [15:0] seq;
  } pkt_t;

  typedef struct {
    rsjls_pkg::seq_status_t status;
    logic [31:0] seen;
    logic [31:0] oos;
    logic [31:0] expd;
    logic [31:0] lost;
    logic [47:0] gmax;
    logic [39:0] jit;
    logic [39:0] jpk;
    logic [39:0] javg;
  } stats_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [17:0] cfg_wdata;

  rsjls_in_if in_ch ();
  rsjls_out_if out_ch ();

  rtp_stream_jitter_loss_stats_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // packets waiting to be driven and statistics waiting to come out
  pkt_t   pkt_pending[$];
  stats_t stats_due[$];
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  // mirror of the block's configuration and statistics state
  logic        m_codec;
  logic [17:0] m_rate;
  logic [31:0] m_cnt, m_cyc, m_oos, m_expd, m_lost;
  logic [47:0] m_arr, m_gmax;
  logic [31:0] m_ts;
  logic [15:0] m_last, m_base;
  logic [39:0] m_jit, m_jpk, m_javg;

  // stream generator state
  logic [47:0] g_arr;
  logic [31:0] g_ts;
  logic [15:0] g_seq;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // advance the mirror by one packet and form the statistics it produces
  task automatic predict_stats(input pkt_t p, output stats_t r);
    longint last, cur, dr, dts, ds, d, ex;
    longint unsigned mag, clkv, ad, nj, cs;
    logic [127:0] acc, q;
    rsjls_pkg::seq_status_t st;
    last = longint'(m_last);
    cur = longint'(p.seq);
    m_cnt = sat_inc(m_cnt);
    if (!m_codec) begin
      st = rsjls_pkg::ST_UNANALYZED;
    end else if (m_cnt == 32'd1) begin
      // first analyzed packet only stores its references
      m_arr = p.arr;
      m_ts = p.ts;
      m_last = p.seq;
      m_base = p.seq;
      st = rsjls_pkg::ST_FIRST;
    end else begin
      if (last + 1 == cur) st = rsjls_pkg::ST_IN_ORDER;
      else if (last == 65535 && cur == 0) st = rsjls_pkg::ST_WRAP;
      else if (last - cur > longint'(rsjls_pkg::NEW_CYCLE_DROP)) st = rsjls_pkg::ST_NEW_CYCLE;
      else if (last + 1 < cur) st = rsjls_pkg::ST_GAP;
      else st = rsjls_pkg::ST_LATE;
      if (st == rsjls_pkg::ST_GAP || st == rsjls_pkg::ST_LATE) m_oos = sat_inc(m_oos);
      if (st == rsjls_pkg::ST_WRAP || st == rsjls_pkg::ST_NEW_CYCLE) begin
        cs = longint'(m_cyc) + longint'(rsjls_pkg::SEQ_SPAN) - longint'(m_base);
        m_cyc = (cs > M32) ? 32'hFFFF_FFFF : cs[31:0];
        m_base = 16'd0;
      end
      if (st != rsjls_pkg::ST_LATE) begin
        m_last = p.seq;
        dr = longint'({16'b0, p.arr}) - longint'({16'b0, m_arr});
        dts = longint'({32'b0, p.ts}) - longint'({32'b0, m_ts});
        clkv = (m_rate == 18'd0) ? 1 : longint'(m_rate);
        mag = (dts < 0) ? -dts : dts;
        ds = longint'((mag * 64'd256000000) / clkv);
        if (dts < 0) ds = -ds;
        // a negative arrival gap never raises the maximum
        if (dr > 0 && longint'(dr) > longint'({16'b0, m_gmax})) m_gmax = dr[47:0];
        d = dr * 256 - ds;
        ad = (d < 0) ? -d : d;
        if (ad >= longint'(m_jit)) begin
          nj = m_jit + ((ad - m_jit) >> rsjls_pkg::JIT_SHIFT);
          if (nj > M40) nj = M40;
        end else begin
          nj = m_jit - ((m_jit - ad) >> rsjls_pkg::JIT_SHIFT);
        end
        if (nj > m_jpk) m_jpk = nj[39:0];
        acc = 128'(m_javg) * 128'(m_cnt) + 128'(nj);
        q = acc / (128'(m_cnt) + 128'd1);
        m_javg = q[39:0];
        m_arr = p.arr;
        m_ts = p.ts;
        m_jit = nj[39:0];
        ex = longint'(m_cyc) + (cur - longint'(m_base) + 1);
        if (ex < 0) ex = 0;
        if (ex > longint'(M32)) ex = M32;
        m_expd = ex[31:0];
        ex = ex - longint'(m_cnt);
        if (ex > 64'sd2147483647) ex = 64'sd2147483647;
        if (ex < -64'sd2147483648) ex = -64'sd2147483648;
        m_lost = ex[31:0];
      end
    end
    r.status = st;
    r.seen = m_cnt;
    r.oos = m_oos;
    r.expd = m_expd;
    r.lost = m_lost;
    r.gmax = m_gmax;
    r.jit = m_jit;
    r.jpk = m_jpk;
    r.javg = m_javg;
  endtask

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s expected %h actual %h", $realtime, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  logic in_took;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_took)) begin
      if (gap_left > 0 || pkt_pending.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.arrival_time_us <= pkt_pending[0].arr;
        in_ch.rtp_timestamp <= pkt_pending[0].ts;
        in_ch.rtp_sequence <= pkt_pending[0].seq;
        void'(pkt_pending.pop_front());
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          // mostly short gaps, sometimes long enough to cover a whole packet
          gap_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 160)
                                                  : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stalls on its own pattern: long runs open, then random stalls
  always @(negedge clk) begin
    if (cycle_cnt[9:8] == 2'd0) out_ch.ready <= 1'b1;
    else if (cycle_cnt[9:8] == 2'd1) out_ch.ready <= ($urandom_range(0, 7) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  // input transfers feed the predictor
  always @(posedge clk) begin
    stats_t r;
    pkt_t p;
    in_took <= 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_took <= 1'b1;
      p.arr = in_ch.arrival_time_us;
      p.ts = in_ch.rtp_timestamp;
      p.seq = in_ch.rtp_sequence;
      predict_stats(p, r);
      stats_due.push_back(r);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stats_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (stats_due.size() == 0) begin
        errors++;
        $display("%0t unexpected result transfer status %0d", $realtime, out_ch.seq_status);
      end else begin
        w = stats_due.pop_front();
        check_field("seq_status", w.status, out_ch.seq_status);
        check_field("packets_seen", w.seen, out_ch.packets_seen);
        check_field("out_of_sequence", w.oos, out_ch.out_of_sequence);
        check_field("expected_packets", w.expd, out_ch.expected_packets);
        check_field("lost_packets", w.lost, $unsigned(out_ch.lost_packets));
        check_field("max_gap_us", w.gmax, out_ch.max_gap_us);
        check_field("jitter_now", w.jit, out_ch.jitter_now);
        check_field("jitter_max", w.jpk, out_ch.jitter_max);
        check_field("jitter_mean", w.javg, out_ch.jitter_mean);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_pkt(logic [47:0] a, logic [31:0] t, logic [15:0] s);
    pkt_t p;
    p.arr = a;
    p.ts = t;
    p.seq = s;
    pkt_pending.push_back(p);
  endtask

  // everything sent has come back, then let a packet in flight drain
  task automatic wait_idle();
    while (pkt_pending.size() != 0 || in_ch.valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [17:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rsjls_pkg::CFG_CODEC_KNOWN) m_codec = val[0];
    else m_rate = val;
  endtask

  // mostly a well-formed stream with random content, some broken sequences
  task automatic gen_stream(int unsigned n);
    int unsigned r;
    int unsigned step;
    repeat (n) begin
      r = $urandom_range(0, 99);
      step = (m_rate / 50) + 1;
      g_arr = g_arr + 48'd20000 + $urandom_range(0, 6000) - 48'd3000;
      g_ts = g_ts + step + $urandom_range(0, step / 8 + 1);
      if (r < 78) g_seq = g_seq + 16'd1;
      else if (r < 84) g_seq = g_seq + 16'($urandom_range(2, 30));
      else if (r < 88) g_seq = g_seq - 16'($urandom_range(0, 12));
      else if (r < 91) g_seq = g_seq - 16'($urandom_range(241, 3000));
      else if (r < 93) g_seq = 16'hFFFE;
      else if (r < 95) begin
        // packet arriving earlier than the one before it
        g_arr = g_arr - 48'($urandom_range(1, 90000));
        g_seq = g_seq + 16'd1;
      end else begin
        g_arr = 48'({$urandom, $urandom});
        g_ts = $urandom;
        g_seq = 16'($urandom);
      end
      add_pkt(g_arr, g_ts, g_seq);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = rsjls_pkg::CFG_CODEC_KNOWN;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.arrival_time_us = '0;
    in_ch.rtp_timestamp = '0;
    in_ch.rtp_sequence = '0;
    out_ch.ready = 1'b0;
    m_codec = 1'b0;
    m_rate = rsjls_pkg::CLOCK_RATE_RESET;
    {m_cnt, m_cyc, m_oos, m_expd, m_lost} = '0;
    {m_arr, m_gmax, m_ts, m_last, m_base} = '0;
    {m_jit, m_jpk, m_javg} = '0;
    g_arr = 48'd1000;
    g_ts = 32'd5000;
    g_seq = 16'd100;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first packet, sequence cases and field extremes at 8 khz
    write_reg(rsjls_pkg::CFG_CODEC_KNOWN, 18'd1);
    add_pkt(48'd0, 32'd0, 16'd65533);
    add_pkt(48'd20000, 32'd160, 16'd65534);
    add_pkt(48'd40000, 32'd320, 16'd65535);
    add_pkt(48'd60000, 32'd480, 16'd0);           // wrap to zero
    add_pkt(48'd80000, 32'd640, 16'd1);
    add_pkt(48'd80000, 32'd640, 16'd1);           // duplicate
    add_pkt(48'd85000, 32'd700, 16'd0);           // late
    add_pkt(48'd100000, 32'd800, 16'd9);          // gap
    add_pkt(48'd90000, 32'd700, 16'd10);          // arrival and timestamp go back
    add_pkt(48'd110000, 32'd960, 16'd5000);       // big gap
    add_pkt(48'd130000, 32'd1120, 16'd4000);      // drop over the new cycle bound
    add_pkt(48'd150000, 32'd1280, 16'd4001);
    add_pkt(48'd150000, 32'd1280, 16'd3761);      // drop exactly at the bound
    add_pkt(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'd4002);
    add_pkt(48'd0, 32'd0, 16'd4003);
    add_pkt(48'hFFFF_FFFF_FFFF, 32'd0, 16'd4004);
    add_pkt(48'd0, 32'hFFFF_FFFF, 16'd65535);
    add_pkt(48'd10, 32'd1, 16'd0);
    add_pkt(48'd20, 32'd2, 16'd1);
    wait_idle();

    // random phases through several clock settings; each pause drains the block
    write_reg(rsjls_pkg::CFG_CLOCK_RATE, 18'd192000);
    gen_stream(170);
    wait_idle();
    write_reg(rsjls_pkg::CFG_CLOCK_RATE, 18'd1);
    gen_stream(170);
    wait_idle();
    write_reg(rsjls_pkg::CFG_CODEC_KNOWN, 18'd0);
    write_reg(rsjls_pkg::CFG_CLOCK_RATE, 18'd131071);
    gen_stream(120);
    wait_idle();
    write_reg(rsjls_pkg::CFG_CODEC_KNOWN, 18'd1);
    gen_stream(170);
    wait_idle();
    write_reg(rsjls_pkg::CFG_CLOCK_RATE, 18'd48000);
    gen_stream(170);
    wait_idle();
    write_reg(rsjls_pkg::CFG_CLOCK_RATE, 18'($urandom_range(1, 192000)));
    gen_stream(230);
    wait_idle();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/rsjls_pkg.sv
hdl/rsjls_if.sv
hdl/rsjls_div.sv
hdl/rtp_stream_jitter_loss_stats_top.sv
tb/sv/tb.sv
